// ===== sv/ebie_pkg.sv =====
// ebie_pkg: shared types and constants for the eight-bit instruction executor
// opcode and request codes, the stage payload struct, the bypass pick struct and the operand bypass helper
// no dependencies
package ebie_pkg;

  localparam int NUM_REGS  = 16;
  localparam int REG_IDX_W = 4;
  localparam int DATA_W    = 8;

  // request codes carried by in_req_type
  localparam logic [1:0] REQ_EXEC     = 2'd0;
  localparam logic [1:0] REQ_MEM_LOAD = 2'd1;
  localparam logic [1:0] REQ_REG_LOAD = 2'd2;

  typedef enum logic [3:0] {
    OP_ADD  = 4'h0,
    OP_SUB  = 4'h1,
    OP_MUL  = 4'h2,
    OP_INC  = 4'h3,
    OP_AND  = 4'h4,
    OP_OR   = 4'h5,
    OP_XOR  = 4'h6,
    OP_NOT  = 4'h7,
    OP_SHL  = 4'h8,
    OP_SHR  = 4'h9,
    OP_LDI  = 4'hA,
    OP_LD   = 4'hB,
    OP_ST   = 4'hC,
    OP_JMP  = 4'hD,
    OP_BEZ  = 4'hE,
    OP_HALT = 4'hF
  } op_t;

  // bypass pick for one register operand
  typedef struct packed {
    logic              sel;
    logic [DATA_W-1:0] val;
  } fwd_t;

  // result stage payload
  typedef struct packed {
    logic [DATA_W-1:0]    pc;
    logic                 halted;
    logic                 br;
    logic                 rw;
    logic [REG_IDX_W-1:0] ri;
    logic [DATA_W-1:0]    rv;
    logic                 ld;
    logic                 mw;
    logic [DATA_W-1:0]    ma;
    logic [DATA_W-1:0]    mv;
  } stage2_t;

  // youngest writer wins: execute stage first, then result stage
  function automatic fwd_t fwd_pick(
    input logic [REG_IDX_W-1:0] idx,
    input logic                 hit1,
    input logic [REG_IDX_W-1:0] ri1,
    input logic [DATA_W-1:0]    v1,
    input logic                 hit2,
    input logic [REG_IDX_W-1:0] ri2,
    input logic [DATA_W-1:0]    v2
  );
    fwd_t f;
    f.sel = 1'b0;
    f.val = '0;
    if (hit1 && (ri1 == idx)) begin
      f.sel = 1'b1;
      f.val = v1;
    end else if (hit2 && (ri2 == idx)) begin
      f.sel = 1'b1;
      f.val = v2;
    end
    return f;
  endfunction

endpackage

// ===== sv/eight_bit_instruction_executor_unit.sv =====
// eight_bit_instruction_executor_unit: top level of the eight-bit instruction executor
// holds register file, data store, pc and halt state, execute and result stages
// depends on ebie_pkg
//
// One beat in per clock, one result beat out per beat taken, through the execute and result stage registers.
// A beat is taken at a rising edge with start high and busy low; busy never rises,
// so the block can take a beat in every cycle. The result shows on the out_ ports for
// exactly one cycle, flagged by out_strobe, and cannot be held off by the receiver.
// Flow: the beat is captured together with its register file reads (a synchronous
// read of three operands, with bypass from the two stages ahead), executed in one
// pass (alu, 8x8 multiply, address add, pc update, data store write), then the
// result stage holds the report while the data store read of a load comes back
// and the register file is written. A load result reaches the next beat through a
// late bypass into the execute stage, so no bubble is inserted. The data store and
// register file read as zero after reset through per-entry valid flops, so no
// clearing sweep is needed. Memory addresses map onto MEM_BYTES entries modulo
// MEM_BYTES through a constant table.
module eight_bit_instruction_executor_unit #(
  parameter int MEM_BYTES = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  // command channel
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_req_type,
  input  logic [15:0] in_instruction,
  input  logic [7:0]  in_load_address,
  input  logic [7:0]  in_load_value,
  // result channel
  output logic        out_strobe,
  output logic [7:0]  out_next_pc,
  output logic        out_halted,
  output logic        out_branch_taken,
  output logic        out_reg_written,
  output logic [3:0]  out_reg_index,
  output logic [7:0]  out_reg_value,
  output logic        out_mem_written,
  output logic [7:0]  out_mem_address,
  output logic [7:0]  out_mem_value
);

  localparam int AW = $clog2(MEM_BYTES);

  typedef logic [AW-1:0] slot_tbl_t [0:255];

  // address to store entry, address modulo MEM_BYTES, built at elaboration
  function automatic slot_tbl_t build_slots();
    slot_tbl_t t;
    for (int i = 0; i < 256; i++) begin
      t[i] = AW'(i % MEM_BYTES);
    end
    return t;
  endfunction

  localparam slot_tbl_t SLOT_TBL = build_slots();

  logic accept;

  // storage
  logic [7:0] rf_a [ebie_pkg::NUM_REGS];   // read at s1 and s2
  logic [7:0] rf_b [ebie_pkg::NUM_REGS];   // copy, read at d
  logic [ebie_pkg::NUM_REGS-1:0] rf_vld_r;
  logic [7:0] mem [MEM_BYTES];
  logic [MEM_BYTES-1:0] mem_vld_r;

  logic [7:0] pc_r;
  logic       halt_r;

  // execute stage registers
  logic        s1_vld_r;
  logic [1:0]  s1_req_r;
  logic [15:0] s1_ins_r;
  logic [7:0]  s1_laddr_r;
  logic [7:0]  s1_lval_r;
  logic [7:0]  rfa_r, rfb_r, rfd_r;
  ebie_pkg::fwd_t fwd_a_r, fwd_b_r, fwd_d_r;
  ebie_pkg::fwd_t fwd_a, fwd_b, fwd_d;

  // result stage registers
  logic              s2_vld_r;
  ebie_pkg::stage2_t s2_r, s2_nxt;
  logic [7:0]        mem_q_r;
  logic              mem_hit_r;

  // execute stage decode and operands
  ebie_pkg::op_t op;
  logic [3:0] f_d, f_s1, f_s2;
  logic [7:0] opa, opb, opd;
  logic [7:0] pc_inc, pc_nxt;
  logic       halt_nxt;
  logic [15:0] prod;
  logic [AW-1:0] slot;
  logic [7:0] mem_rdata, s2_wval;
  logic       s2_ld_hit;
  logic       s1_fwd_hit, s2_fwd_hit;

  // every cycle can take a beat
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // load data coming back from the store, zero for never-written entries
  assign mem_rdata = mem_hit_r ? mem_q_r : '0;
  assign s2_wval   = s2_r.ld ? mem_rdata : s2_r.rv;

  // bypass at capture: execute stage result (not a load), then result stage write
  assign s1_fwd_hit = s1_vld_r && s2_nxt.rw && !s2_nxt.ld;
  assign s2_fwd_hit = s2_vld_r && s2_r.rw;

  always_comb begin
    fwd_a = ebie_pkg::fwd_pick(in_instruction[7:4], s1_fwd_hit, s2_nxt.ri, s2_nxt.rv,
                               s2_fwd_hit, s2_r.ri, s2_wval);
    fwd_b = ebie_pkg::fwd_pick(in_instruction[3:0], s1_fwd_hit, s2_nxt.ri, s2_nxt.rv,
                               s2_fwd_hit, s2_r.ri, s2_wval);
    fwd_d = ebie_pkg::fwd_pick(in_instruction[11:8], s1_fwd_hit, s2_nxt.ri, s2_nxt.rv,
                               s2_fwd_hit, s2_r.ri, s2_wval);
  end

  // capture the beat with its register file reads
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_req_r   <= in_req_type;
      s1_ins_r   <= in_instruction;
      s1_laddr_r <= in_load_address;
      s1_lval_r  <= in_load_value;
      fwd_a_r    <= fwd_a;
      fwd_b_r    <= fwd_b;
      fwd_d_r    <= fwd_d;
    end
  end

  always_ff @(posedge clk) begin
    rfa_r <= rf_vld_r[in_instruction[7:4]]  ? rf_a[in_instruction[7:4]]  : '0;
    rfb_r <= rf_vld_r[in_instruction[3:0]]  ? rf_a[in_instruction[3:0]]  : '0;
    rfd_r <= rf_vld_r[in_instruction[11:8]] ? rf_b[in_instruction[11:8]] : '0;
  end

  // register file write from the result stage
  always_ff @(posedge clk) begin
    if (s2_vld_r && s2_r.rw) begin
      rf_a[s2_r.ri] <= s2_wval;
      rf_b[s2_r.ri] <= s2_wval;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rf_vld_r <= '0;
    end else if (s2_vld_r && s2_r.rw) begin
      rf_vld_r[s2_r.ri] <= 1'b1;
    end
  end

  // execute stage
  assign op   = ebie_pkg::op_t'(s1_ins_r[15:12]);
  assign f_d  = s1_ins_r[11:8];
  assign f_s1 = s1_ins_r[7:4];
  assign f_s2 = s1_ins_r[3:0];

  // late bypass of a load that sits in the result stage
  assign s2_ld_hit = s2_vld_r && s2_r.rw && s2_r.ld;

  always_comb begin
    if (s2_ld_hit && (s2_r.ri == f_s1)) begin
      opa = mem_rdata;
    end else if (fwd_a_r.sel) begin
      opa = fwd_a_r.val;
    end else begin
      opa = rfa_r;
    end
    if (s2_ld_hit && (s2_r.ri == f_s2)) begin
      opb = mem_rdata;
    end else if (fwd_b_r.sel) begin
      opb = fwd_b_r.val;
    end else begin
      opb = rfb_r;
    end
    if (s2_ld_hit && (s2_r.ri == f_d)) begin
      opd = mem_rdata;
    end else if (fwd_d_r.sel) begin
      opd = fwd_d_r.val;
    end else begin
      opd = rfd_r;
    end
  end

  assign pc_inc = pc_r + 8'd2;
  assign prod   = {8'd0, opa} * {8'd0, opb};

  always_comb begin
    s2_nxt        = '0;
    s2_nxt.pc     = pc_r;
    s2_nxt.halted = halt_r;
    pc_nxt        = pc_r;
    halt_nxt      = halt_r;
    case (s1_req_r)
      ebie_pkg::REQ_MEM_LOAD: begin
        s2_nxt.mw = 1'b1;
        s2_nxt.ma = s1_laddr_r;
        s2_nxt.mv = s1_lval_r;
      end
      ebie_pkg::REQ_REG_LOAD: begin
        s2_nxt.rw = 1'b1;
        s2_nxt.ri = s1_laddr_r[3:0];
        s2_nxt.rv = s1_lval_r;
      end
      ebie_pkg::REQ_EXEC: begin
        // a halted machine ignores execute beats
        if (!halt_r) begin
          pc_nxt    = pc_inc;
          s2_nxt.rw = 1'b1;
          s2_nxt.ri = f_d;
          case (op)
            ebie_pkg::OP_ADD: s2_nxt.rv = opa + opb;
            ebie_pkg::OP_SUB: s2_nxt.rv = opa - opb;
            ebie_pkg::OP_MUL: s2_nxt.rv = prod[7:0];
            ebie_pkg::OP_INC: s2_nxt.rv = opd + 8'd1;
            ebie_pkg::OP_AND: s2_nxt.rv = opa & opb;
            ebie_pkg::OP_OR:  s2_nxt.rv = opa | opb;
            ebie_pkg::OP_XOR: s2_nxt.rv = opa ^ opb;
            ebie_pkg::OP_NOT: s2_nxt.rv = ~opa;
            ebie_pkg::OP_SHL: s2_nxt.rv = opa << f_s2;
            ebie_pkg::OP_SHR: s2_nxt.rv = opa >> f_s2;
            ebie_pkg::OP_LDI: s2_nxt.rv = {f_s1, f_s2};
            ebie_pkg::OP_LD: begin
              s2_nxt.ld = 1'b1;
              s2_nxt.ma = opa + {4'b0, f_s2};
            end
            ebie_pkg::OP_ST: begin
              s2_nxt.rw = 1'b0;
              s2_nxt.ri = '0;
              s2_nxt.mw = 1'b1;
              s2_nxt.ma = opa + {4'b0, f_s2};
              s2_nxt.mv = opd;
            end
            ebie_pkg::OP_JMP: begin
              // offset times two, wrap makes the sign fall out
              s2_nxt.rw = 1'b0;
              s2_nxt.ri = '0;
              s2_nxt.br = 1'b1;
              pc_nxt    = pc_inc + {f_d[2:0], f_s1, 1'b0};
            end
            ebie_pkg::OP_BEZ: begin
              s2_nxt.rw = 1'b0;
              s2_nxt.ri = '0;
              if (opd == 8'd0) begin
                s2_nxt.br = 1'b1;
                pc_nxt    = pc_inc + {f_s1[2:0], f_s2, 1'b0};
              end
            end
            default: begin
              // halt
              s2_nxt.rw = 1'b0;
              s2_nxt.ri = '0;
              halt_nxt  = 1'b1;
            end
          endcase
          s2_nxt.pc     = pc_nxt;
          s2_nxt.halted = halt_nxt;
        end
      end
      default: begin
        // unused request code reports state only
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r   <= '0;
      halt_r <= 1'b0;
    end else if (s1_vld_r) begin
      pc_r   <= pc_nxt;
      halt_r <= halt_nxt;
    end
  end

  // data store: read each cycle, written on a store or memory load beat, at the execute stage address
  assign slot = SLOT_TBL[s2_nxt.ma];

  always_ff @(posedge clk) begin
    if (s1_vld_r && s2_nxt.mw) begin
      mem[slot] <= s2_nxt.mv;
    end
  end

  always_ff @(posedge clk) begin
    mem_q_r   <= mem[slot];
    mem_hit_r <= mem_vld_r[slot];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mem_vld_r <= '0;
    end else if (s1_vld_r && s2_nxt.mw) begin
      mem_vld_r[slot] <= 1'b1;
    end
  end

  // result stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else begin
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s2_r <= s2_nxt;
  end

  assign out_strobe       = s2_vld_r;
  assign out_next_pc      = s2_r.pc;
  assign out_halted       = s2_r.halted;
  assign out_branch_taken = s2_r.br;
  assign out_reg_written  = s2_r.rw;
  assign out_reg_index    = s2_r.ri;
  assign out_reg_value    = s2_wval;
  assign out_mem_written  = s2_r.mw;
  assign out_mem_address  = s2_r.ma;
  assign out_mem_value    = s2_r.ld ? mem_rdata : s2_r.mv;

  // once halted, the machine stays halted and its pc stays put
  a_halt_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_vld_r && halt_r) |=> (halt_r && (pc_r == $past(pc_r))))
    else $error("halted machine changed pc or halt flag");

  // a beat writes either a register or the data store, never both
  a_one_target: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !(out_reg_written && out_mem_written))
    else $error("result reports both register and memory write");

  // a taken branch comes from a running machine and does not halt it
  a_branch_running: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_branch_taken) |-> (!out_halted && !out_reg_written))
    else $error("branch reported on halted machine or with register write");

endmodule
